@@ rtl/uhe_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// uhe_pkg
// Shared types, constants and byte tables of the HTML-escaping UTF-8 encoder.
// ----------------------------------------------------------------------------
package uhe_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam int unsigned CP_W   = 21;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 3;

  localparam logic [CP_W-1:0] CP_AMP  = 21'h000026;
  localparam logic [CP_W-1:0] CP_QUOT = 21'h000022;
  localparam logic [CP_W-1:0] CP_APOS = 21'h000027;
  localparam logic [CP_W-1:0] CP_LT   = 21'h00003C;
  localparam logic [CP_W-1:0] CP_GT   = 21'h00003E;

  localparam logic [CP_W-1:0] LIM_1B = 21'h00007F;
  localparam logic [CP_W-1:0] LIM_2B = 21'h0007FF;
  localparam logic [CP_W-1:0] LIM_3B = 21'h00FFFF;
  localparam logic [CP_W-1:0] LIM_4B = 21'h10FFFF;

  localparam logic [BYTE_W-1:0] LEAD_2B = 8'hC0;
  localparam logic [BYTE_W-1:0] LEAD_3B = 8'hE0;
  localparam logic [BYTE_W-1:0] LEAD_4B = 8'hF0;
  localparam logic [BYTE_W-1:0] CONT_B  = 8'h80;

  localparam logic [LEN_W-1:0] LEN_NONE = 3'd0;
  localparam logic [LEN_W-1:0] LEN_1B   = 3'd1;
  localparam logic [LEN_W-1:0] LEN_2B   = 3'd2;
  localparam logic [LEN_W-1:0] LEN_3B   = 3'd3;
  localparam logic [LEN_W-1:0] LEN_4B   = 3'd4;
  localparam logic [LEN_W-1:0] LEN_AMP  = 3'd5;
  localparam logic [LEN_W-1:0] LEN_QUOT = 3'd6;
  localparam logic [LEN_W-1:0] LEN_APOS = 3'd6;
  localparam logic [LEN_W-1:0] LEN_LT   = 3'd4;
  localparam logic [LEN_W-1:0] LEN_GT   = 3'd4;

  // entity text, left aligned, zero padded
  localparam logic [47:0] ENT_AMP  = {"&amp;", 8'h00};
  localparam logic [47:0] ENT_QUOT = "&quot;";
  localparam logic [47:0] ENT_APOS = "&apos;";
  localparam logic [47:0] ENT_LT   = {"&lt;", 16'h0000};
  localparam logic [47:0] ENT_GT   = {"&gt;", 16'h0000};

  typedef enum logic [2:0] {
    KIND_UTF8,
    KIND_AMP,
    KIND_QUOT,
    KIND_APOS,
    KIND_LT,
    KIND_GT
  } kind_t;

  typedef struct packed {
    kind_t            kind;
    logic [LEN_W-1:0] len;
    logic [CP_W-1:0]  cp;
    logic             str_end;
  } item_desc_t;

  function automatic logic [BYTE_W-1:0] text_byte(logic [47:0] txt, logic [LEN_W-1:0] idx);
    logic [BYTE_W-1:0] b;
    unique case (idx)
      3'd0:    b = txt[47:40];
      3'd1:    b = txt[39:32];
      3'd2:    b = txt[31:24];
      3'd3:    b = txt[23:16];
      3'd4:    b = txt[15:8];
      default: b = txt[7:0];
    endcase
    return b;
  endfunction

  function automatic logic [BYTE_W-1:0] utf8_byte(logic [LEN_W-1:0] len,
                                                   logic [LEN_W-1:0] idx,
                                                   logic [CP_W-1:0]  cp);
    logic [BYTE_W-1:0] b;
    unique case (len)
      LEN_2B: begin
        if (idx == 3'd0) b = LEAD_2B | {3'b000, cp[10:6]};
        else             b = CONT_B | {2'b00, cp[5:0]};
      end
      LEN_3B: begin
        unique case (idx)
          3'd0:    b = LEAD_3B | {4'b0000, cp[15:12]};
          3'd1:    b = CONT_B | {2'b00, cp[11:6]};
          default: b = CONT_B | {2'b00, cp[5:0]};
        endcase
      end
      LEN_4B: begin
        unique case (idx)
          3'd0:    b = LEAD_4B | {5'b00000, cp[20:18]};
          3'd1:    b = CONT_B | {2'b00, cp[17:12]};
          3'd2:    b = CONT_B | {2'b00, cp[11:6]};
          default: b = CONT_B | {2'b00, cp[5:0]};
        endcase
      end
      default: b = cp[7:0];
    endcase
    return b;
  endfunction

  function automatic logic [BYTE_W-1:0] desc_byte(item_desc_t d, logic [LEN_W-1:0] idx);
    logic [BYTE_W-1:0] b;
    unique case (d.kind)
      KIND_AMP:  b = text_byte(ENT_AMP, idx);
      KIND_QUOT: b = text_byte(ENT_QUOT, idx);
      KIND_APOS: b = text_byte(ENT_APOS, idx);
      KIND_LT:   b = text_byte(ENT_LT, idx);
      KIND_GT:   b = text_byte(ENT_GT, idx);
      default:   b = utf8_byte(d.len, idx, d.cp);
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

@@ rtl/uhe_front.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// uhe_front
// Accepts code points and classifies each into an entity or a UTF-8 length.
// ----------------------------------------------------------------------------
module uhe_front
  import uhe_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [CP_W-1:0] in_code_point,
  input  wire logic            in_string_end,
  input  wire logic            q_full,
  output logic                 q_push,
  output item_desc_t           q_desc
);

  always_comb begin
    q_desc.cp      = in_code_point;
    q_desc.str_end = in_string_end;
    q_desc.kind    = KIND_UTF8;
    q_desc.len     = LEN_NONE;
    priority if (in_code_point == CP_AMP) begin
      q_desc.kind = KIND_AMP;
      q_desc.len  = LEN_AMP;
    end else if (in_code_point == CP_QUOT) begin
      q_desc.kind = KIND_QUOT;
      q_desc.len  = LEN_QUOT;
    end else if (in_code_point == CP_APOS) begin
      q_desc.kind = KIND_APOS;
      q_desc.len  = LEN_APOS;
    end else if (in_code_point == CP_LT) begin
      q_desc.kind = KIND_LT;
      q_desc.len  = LEN_LT;
    end else if (in_code_point == CP_GT) begin
      q_desc.kind = KIND_GT;
      q_desc.len  = LEN_GT;
    end else if (in_code_point <= LIM_1B) begin
      q_desc.len = LEN_1B;
    end else if (in_code_point <= LIM_2B) begin
      q_desc.len = LEN_2B;
    end else if (in_code_point <= LIM_3B) begin
      q_desc.len = LEN_3B;
    end else if (in_code_point <= LIM_4B) begin
      q_desc.len = LEN_4B;
    end else begin
      q_desc.len = LEN_NONE;
    end
  end

  assign in_ready = !q_full;
  // out of range beats are taken and dropped
  assign q_push   = in_valid && in_ready && (q_desc.len != LEN_NONE);

`ifndef NO_ASSERTIONS
  a_push_has_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (q_desc.len != LEN_NONE) && (q_desc.len <= LEN_QUOT))
    else $error("descriptor with bad length queued");
`endif

endmodule
`default_nettype wire

@@ rtl/uhe_queue.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// uhe_queue
// Short descriptor queue between the classifier and the byte serializer.
// ----------------------------------------------------------------------------
module uhe_queue
  import uhe_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  item_desc_t      wdata,
  output logic            full,
  input  wire logic       pop,
  output logic            head_valid,
  output item_desc_t      head
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  item_desc_t       slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) count_nxt = count_r + CNT_W'(1);
    else if (pop && !push) count_nxt = count_r - CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots_r[wr_ptr_r] <= wdata;
  end

  assign full       = (count_r == CNT_W'(DEPTH));
  assign head_valid = (count_r != '0);
  assign head       = slots_r[rd_ptr_r];

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |-> !full)
    else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("pop from empty queue");
  a_ptrs_meet_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("pointers apart while queue empty");
`endif

endmodule
`default_nettype wire

@@ rtl/uhe_back.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// uhe_back
// Serializes queued descriptors into bytes, one per beat, into the output
// register.
// ----------------------------------------------------------------------------
module uhe_back
  import uhe_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              head_valid,
  input  item_desc_t             head,
  output logic                   pop,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [BYTE_W-1:0]      out_byte,
  output logic                   out_last,
  output logic                   out_string_done
);

  item_desc_t        cur_r, cur_nxt;
  logic              cur_valid_r, cur_valid_nxt;
  logic [LEN_W-1:0]  idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic              out_last_r, out_last_nxt;
  logic              out_done_r, out_done_nxt;

  item_desc_t        src;
  logic [LEN_W-1:0]  src_idx;
  logic              src_ok;
  logic              fin;
  logic              adv;

  always_comb begin
    src     = cur_valid_r ? cur_r : head;
    src_idx = cur_valid_r ? idx_r : '0;
    src_ok  = cur_valid_r || head_valid;
    fin     = (src_idx == LEN_W'(src.len - LEN_W'(1)));
    adv     = !out_valid_r || out_ready;

    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    out_done_nxt  = out_done_r;
    pop           = 1'b0;

    if (adv) begin
      out_valid_nxt = src_ok;
      if (src_ok) begin
        out_byte_nxt = desc_byte(src, src_idx);
        out_last_nxt = fin;
        out_done_nxt = fin && src.str_end;
      end
      if (cur_valid_r) begin
        if (fin) cur_valid_nxt = 1'b0;
        else     idx_nxt = idx_r + LEN_W'(1);
      end else if (head_valid) begin
        pop = 1'b1;
        // multi byte item: park it and continue from the second byte
        if (!fin) begin
          cur_nxt       = head;
          cur_valid_nxt = 1'b1;
          idx_nxt       = LEN_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    idx_r      <= idx_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
    out_done_r <= out_done_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_byte        = out_byte_r;
  assign out_last        = out_last_r;
  assign out_string_done = out_done_r;

`ifndef NO_ASSERTIONS
  a_idx_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r |-> (idx_r != '0) && (idx_r < cur_r.len))
    else $error("byte index outside current run");
  a_done_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_done_r |-> out_last_r)
    else $error("string done flagged on non-final byte");
  a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
    cur_valid_r && !adv |=> cur_valid_r && $stable(idx_r))
    else $error("run advanced while output stalled");
`endif

endmodule
`default_nettype wire

@@ rtl/utf8_encode_html_escape.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// utf8_encode_html_escape
// HTML-escaping UTF-8 encoder, top level.
//
// Input channel (in_valid/in_ready): one code point and an end-of-string flag
// per beat. Output channel (out_valid/out_ready): one byte per beat with
// out_last on the final byte of each code point and out_string_done on the
// final byte of a code point that carried the end-of-string flag.
// & " ' < > become the entities &amp; &quot; &apos; &lt; &gt; (4 to 6 bytes),
// every other code point its UTF-8 form (1 to 4 bytes), surrogates included.
// A code point above 0x10FFFF is taken and yields no bytes.
// The input beat is written into the descriptor queue and its first byte then
// into the output register. Throughput: one output byte per cycle while
// out_ready is high; input is taken back to back while the descriptor queue
// (QUEUE_DEPTH entries) has room.
// A stalled receiver holds the output register; the serializer and then the
// queue fill, and in_ready falls once the queue is full.
// Reset (rst_n low, synchronous) empties the queue and the output register.
// ----------------------------------------------------------------------------
module utf8_encode_html_escape
  import uhe_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [CP_W-1:0]   in_code_point,
  input  wire logic              in_string_end,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [BYTE_W-1:0]      out_byte,
  output logic                   out_last,
  output logic                   out_string_done
);

  logic       q_full;
  logic       q_push;
  item_desc_t q_desc;
  logic       q_pop;
  logic       q_head_valid;
  item_desc_t q_head;

  uhe_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_code_point (in_code_point),
    .in_string_end (in_string_end),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_desc        (q_desc)
  );

  uhe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .wdata      (q_desc),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  uhe_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head_valid      (q_head_valid),
    .head            (q_head),
    .pop             (q_pop),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_byte        (out_byte),
    .out_last        (out_last),
    .out_string_done (out_string_done)
  );

endmodule
`default_nettype wire
